### hdl/ida_pkg.sv
// ============================================================================
// ida_pkg
// Shared types and constants for the identifier allocator.
// ============================================================================
`default_nettype none

package ida_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 9;

    localparam int MAX_IDS_DEF = 256;

    localparam logic [COUNT_W-1:0] UPPER_BOUND_RST = 9'd256;

    localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_LIMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE        = 2'd2;

    // Move command for the free-list cell chain.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

endpackage

`default_nettype wire

### hdl/ida_req_if.sv
// ============================================================================
// ida_req_if
// Request channel: operation, freed identifier and live-count limit.
// ============================================================================
`default_nettype none

interface ida_req_if;
    import ida_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    free_id;
    logic [COUNT_W-1:0] limit;

    modport source (output valid, output op, output free_id, output limit, input ready);
    modport sink   (input valid, input op, input free_id, input limit, output ready);
endinterface

`default_nettype wire

### hdl/ida_rsp_if.sv
// ============================================================================
// ida_rsp_if
// Response channel: success flag, identifier and live count.
// ============================================================================
`default_nettype none

interface ida_rsp_if;
    import ida_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] live_count;

    modport source (output valid, output ok, output id, output live_count, input ready);
    modport sink   (input valid, input ok, input id, input live_count, output ready);
endinterface

`default_nettype wire

### hdl/ida_stack_cell.sv
// ============================================================================
// ida_stack_cell
// One entry of the free-list chain; loads from above on push, below on pop.
// ============================================================================
`default_nettype none

module ida_stack_cell (
    input  wire                      clk,
    input  ida_pkg::stack_cmd_t      cmd,
    input  wire [ida_pkg::ID_W-1:0]  above,
    input  wire [ida_pkg::ID_W-1:0]  below,
    output logic [ida_pkg::ID_W-1:0] value
);
    import ida_pkg::*;

    logic [ID_W-1:0] value_reg;
    logic [ID_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.push)
        begin
            value_next = above;
        end
        else if (cmd.pop)
        begin
            value_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### hdl/ida_stack.sv
// ============================================================================
// ida_stack
// Free-list LIFO built as a shifting chain of cells; cell 0 is the top.
// ============================================================================
`default_nettype none

module ida_stack #(
    parameter int DEPTH = ida_pkg::MAX_IDS_DEF
) (
    input  wire                      clk,
    input  ida_pkg::stack_cmd_t      cmd,
    input  wire [ida_pkg::ID_W-1:0]  push_data,
    output logic [ida_pkg::ID_W-1:0] top
);
    import ida_pkg::*;

    logic [ID_W-1:0] cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] above;
        logic [ID_W-1:0] below;

        if (i == 0)
        begin : g_head
            assign above = push_data;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end

        // Bottom cell keeps its own value on pop; it is beyond the depth then.
        if (i == DEPTH - 1)
        begin : g_tail
            assign below = cell_q[i];
        end
        else
        begin : g_inner
            assign below = cell_q[i+1];
        end

        ida_stack_cell u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .above (above),
            .below (below),
            .value (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule

`default_nettype wire

### hdl/id_allocator_top.sv
// ============================================================================
// id_allocator_top
// Identifier allocator with a LIFO free list and a high-water fresh counter.
// ============================================================================
// The allocator takes one request per clock cycle while ready, and returns its
// response in the next cycle from an output register; a new request is taken
// while that response waits, as long as the response slot is free or being
// drained. The free list is a chain of MAX_IDS shifting cells whose top cell
// is always readable, so a pop, a push and the counter updates finish in the
// cycle of the request. Freed identifiers are reused first, newest first;
// otherwise a fresh identifier is minted below min(upper_bound, MAX_IDS). The
// free list contents need no clearing after reset. Write upper_bound only while idle.
`default_nettype none

module id_allocator_top #(
    parameter int MAX_IDS = ida_pkg::MAX_IDS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    ida_req_if.sink                      req,
    ida_rsp_if.source                    rsp,
    input  wire                          cfg_we,
    input  wire [ida_pkg::COUNT_W-1:0]   cfg_wdata
);
    import ida_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_IDS + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_IDS);
    localparam logic [COUNT_W-1:0] BOUND_CAP  =
        (MAX_IDS < (1 << COUNT_W)) ? COUNT_W'(MAX_IDS) : {COUNT_W{1'b1}};
    localparam int SUM_W = (DEPTH_W > COUNT_W) ? DEPTH_W + 1 : COUNT_W + 1;

    logic [COUNT_W-1:0] bound_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [COUNT_W-1:0] fresh_reg;
    logic [COUNT_W-1:0] fresh_next;
    logic [COUNT_W-1:0] live_reg;
    logic [COUNT_W-1:0] live_next;

    logic               rsp_valid_reg;
    logic               rsp_ok_reg;
    logic [ID_W-1:0]    rsp_id_reg;
    logic [COUNT_W-1:0] rsp_live_reg;

    logic               accept;
    logic [COUNT_W-1:0] eff_bound;
    logic               stack_nonempty;
    logic               can_take;
    logic               take_req;
    logic               take_ok;
    logic               free_ok;
    logic [ID_W-1:0]    top;
    logic [ID_W-1:0]    take_id;
    stack_cmd_t         cmd;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign eff_bound      = (bound_reg > BOUND_CAP) ? BOUND_CAP : bound_reg;
    assign stack_nonempty = (depth_reg != '0);
    assign can_take       = stack_nonempty || (fresh_reg < eff_bound);

    always_comb
    begin
        take_req = 1'b0;
        free_ok  = 1'b0;
        case (req.op)
            OP_ALLOC:       take_req = 1'b1;
            OP_ALLOC_LIMIT: take_req = (live_reg < req.limit);
            OP_FREE:        free_ok  = (live_reg != '0) && (depth_reg != DEPTH_FULL);
            default:
            begin
                take_req = 1'b0;
                free_ok  = 1'b0;
            end
        endcase
    end

    assign take_ok  = take_req && can_take;
    assign cmd.push = accept && free_ok;
    assign cmd.pop  = accept && take_ok && stack_nonempty;
    assign take_id  = stack_nonempty ? top : fresh_reg[ID_W-1:0];

    ida_stack #(
        .DEPTH (MAX_IDS)
    ) u_stack (
        .clk       (clk),
        .cmd       (cmd),
        .push_data (req.free_id),
        .top       (top)
    );

    always_comb
    begin
        depth_next = depth_reg;
        fresh_next = fresh_reg;
        live_next  = live_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + 1'b1;
            live_next  = live_reg - 1'b1;
        end
        else if (accept && take_ok)
        begin
            live_next = live_reg + 1'b1;
            if (stack_nonempty)
            begin
                depth_next = depth_reg - 1'b1;
            end
            else
            begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg     <= UPPER_BOUND_RST;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bound_reg <= cfg_wdata;
            end
            depth_reg <= depth_next;
            fresh_reg <= fresh_next;
            live_reg  <= live_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload: load on request transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_ok_reg   <= take_ok || free_ok;
            rsp_id_reg   <= take_ok ? take_id : '0;
            rsp_live_reg <= live_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = rsp_ok_reg;
    assign rsp.id         = rsp_id_reg;
    assign rsp.live_count = rsp_live_reg;

    // Every minted id is either live or on the free list.
    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(live_reg) + SUM_W'(depth_reg)) == SUM_W'(fresh_reg))
        else $error("live count plus free-list depth differs from fresh count");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("free list pushed and popped in the same cycle");

    a_free_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (depth_reg == $past(depth_reg) + 1'b1) && rsp.ok && (rsp.id == '0))
        else $error("accepted free did not grow the free list");

endmodule

`default_nettype wire
